FILE: src/ray_refraction_direction_assert.svh
// Assertion macros for the refraction block.
// All checks run on clk_i and are disabled while rst_ni is low.
`ifndef RAY_REFRACTION_DIRECTION_ASSERT_SVH
`define RAY_REFRACTION_DIRECTION_ASSERT_SVH

// Same-cycle implication.
`define RRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define RRD_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##dly (cons)) else $error(msg);

`endif

FILE: src/rrd_pkg.sv
package rrd_pkg;

  localparam int CompW    = 16;
  localparam int IdxW     = 16;
  localparam int FracBits = 14;
  localparam int RatioW   = IdxW + FracBits;
  localparam int CosW     = 20;
  localparam int S14W     = 22;
  localparam int PerpW    = 25;
  localparam int LenW     = 50;
  localparam int RootW    = 25;
  localparam int OutW     = 20;
  localparam int VecStages = 7;
  localparam int OutStages = 2;
  localparam int Latency  = RatioW + VecStages + RootW + OutStages;

  typedef logic [2:0][CompW-1:0] cvec_t;
  typedef logic [2:0][PerpW-1:0] pvec_t;

  typedef struct packed {
    logic              valid;
    logic              err;
    logic [RatioW-1:0] ratio;
    cvec_t             ray;
    cvec_t             nrm;
  } ratio_item_t;

  typedef struct packed {
    logic            valid;
    logic            err;
    cvec_t           nrm;
    pvec_t           perp;
    logic [LenW-1:0] diff;
  } len_item_t;

  typedef struct packed {
    logic             valid;
    logic             err;
    cvec_t            nrm;
    pvec_t            perp;
    logic [RootW-1:0] root;
  } root_item_t;

  typedef struct packed {
    logic [LenW-1:0] rad;
    logic [LenW:0]   res;
  } sq_state_t;

endpackage

FILE: src/rrd_div.sv
module rrd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  rrd_pkg::cvec_t            ray_i,
  input  rrd_pkg::cvec_t            nrm_i,
  input  logic [rrd_pkg::IdxW-1:0]  idx_in_i,
  input  logic [rrd_pkg::IdxW-1:0]  idx_out_i,
  output rrd_pkg::ratio_item_t      item_o
);
  import rrd_pkg::*;

  // one quotient bit per stage, restoring division
  logic              valid_q [RatioW];
  logic [IdxW-1:0]   rem_q   [RatioW];
  logic [IdxW-1:0]   dvs_q   [RatioW];
  logic [RatioW-1:0] num_q   [RatioW];
  logic [RatioW-1:0] quo_q   [RatioW];
  cvec_t             ray_q   [RatioW];
  cvec_t             nrm_q   [RatioW];
  logic [RatioW-1:0] num0;

  function automatic logic div_ge(input logic [IdxW-1:0] rem, input logic b,
                                  input logic [IdxW-1:0] dvs);
    return {rem, b} >= {1'b0, dvs};
  endfunction

  function automatic logic [IdxW-1:0] div_rem(input logic [IdxW-1:0] rem, input logic b,
                                              input logic [IdxW-1:0] dvs);
    logic [IdxW:0] t;
    t = {rem, b};
    if (t >= {1'b0, dvs}) begin
      t = t - {1'b0, dvs};
    end
    return t[IdxW-1:0];
  endfunction

  assign num0 = {idx_in_i, {FracBits{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < RatioW; s++) valid_q[s] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < RatioW; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= div_rem('0, num0[RatioW-1], idx_out_i);
    quo_q[0] <= {{(RatioW-1){1'b0}}, div_ge('0, num0[RatioW-1], idx_out_i)};
    num_q[0] <= num0 << 1;
    dvs_q[0] <= idx_out_i;
    ray_q[0] <= ray_i;
    nrm_q[0] <= nrm_i;
    for (int s = 1; s < RatioW; s++) begin
      rem_q[s] <= div_rem(rem_q[s-1], num_q[s-1][RatioW-1], dvs_q[s-1]);
      quo_q[s] <= {quo_q[s-1][RatioW-2:0],
                   div_ge(rem_q[s-1], num_q[s-1][RatioW-1], dvs_q[s-1])};
      num_q[s] <= num_q[s-1] << 1;
      dvs_q[s] <= dvs_q[s-1];
      ray_q[s] <= ray_q[s-1];
      nrm_q[s] <= nrm_q[s-1];
    end
  end

  assign item_o.valid = valid_q[RatioW-1];
  assign item_o.err   = (dvs_q[RatioW-1] == '0);
  assign item_o.ratio = quo_q[RatioW-1];
  assign item_o.ray   = ray_q[RatioW-1];
  assign item_o.nrm   = nrm_q[RatioW-1];

endmodule

FILE: src/rrd_vec.sv
module rrd_vec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrd_pkg::ratio_item_t item_i,
  output rrd_pkg::len_item_t   item_o
);
  import rrd_pkg::*;

  localparam logic signed [33:0]   OneQ28d = 34'sd1 <<< 28;
  localparam logic [LenW-1:0]      OneQ28l = LenW'(1) << 28;
  localparam logic signed [38:0]   PerpMax = (39'sd1 <<< (PerpW-1)) - 39'sd1;
  localparam logic signed [38:0]   PerpMin = -(39'sd1 <<< (PerpW-1));

  logic [VecStages-1:0] valid_q;

  // stage 1: dot products
  logic                     err1_q;
  logic [RatioW-1:0]        ratio1_q;
  cvec_t                    ray1_q, nrm1_q;
  logic signed [31:0]       pr1_q [3];
  // stage 2: cosine
  logic                     err2_q;
  logic [RatioW-1:0]        ratio2_q;
  cvec_t                    ray2_q, nrm2_q;
  logic signed [CosW-1:0]   cos2_q;
  // stage 3: ray + cos * normal
  logic                     err3_q;
  logic [RatioW-1:0]        ratio3_q;
  cvec_t                    nrm3_q;
  logic signed [S14W-1:0]   s14_q [3];
  // stage 4: ratio product
  logic                     err4_q;
  cvec_t                    nrm4_q;
  logic signed [52:0]       pm4_q [3];
  // stage 5: perpendicular part
  logic                     err5_q;
  cvec_t                    nrm5_q;
  pvec_t                    perp5_q;
  // stage 6: squares
  logic                     err6_q;
  cvec_t                    nrm6_q;
  pvec_t                    perp6_q;
  logic [LenW-1:0]          sq6_q [3];
  // stage 7: |1 - len^2|
  logic                     err7_q;
  cvec_t                    nrm7_q;
  pvec_t                    perp7_q;
  logic [LenW-1:0]          diff7_q;

  logic signed [33:0]       dot_w, cosv_w;
  logic signed [36:0]       s28_w [3];
  logic signed [38:0]       p14_w [3];
  logic signed [LenW-1:0]   pe_w [3];
  logic [LenW-1:0]          lensq_w;

  always_comb begin
    dot_w  = 34'(pr1_q[0]) + 34'(pr1_q[1]) + 34'(pr1_q[2]);
    cosv_w = -dot_w;
    if (cosv_w > OneQ28d) begin
      cosv_w = OneQ28d;
    end
    for (int i = 0; i < 3; i++) begin
      s28_w[i] = (37'($signed(ray2_q[i])) <<< FracBits)
               + 37'(cos2_q) * 37'($signed(nrm2_q[i]));
      p14_w[i] = 39'(pm4_q[i] >>> FracBits);
      if (p14_w[i] > PerpMax) begin
        p14_w[i] = PerpMax;
      end else if (p14_w[i] < PerpMin) begin
        p14_w[i] = PerpMin;
      end
      pe_w[i] = LenW'($signed(perp5_q[i]));
    end
    lensq_w = sq6_q[0] + sq6_q[1] + sq6_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[VecStages-2:0], item_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    err1_q   <= item_i.err;
    ratio1_q <= item_i.ratio;
    ray1_q   <= item_i.ray;
    nrm1_q   <= item_i.nrm;
    for (int i = 0; i < 3; i++) begin
      pr1_q[i] <= 32'($signed(item_i.ray[i])) * 32'($signed(item_i.nrm[i]));
    end

    err2_q   <= err1_q;
    ratio2_q <= ratio1_q;
    ray2_q   <= ray1_q;
    nrm2_q   <= nrm1_q;
    cos2_q   <= CosW'(cosv_w >>> FracBits);

    err3_q   <= err2_q;
    ratio3_q <= ratio2_q;
    nrm3_q   <= nrm2_q;
    for (int i = 0; i < 3; i++) begin
      s14_q[i] <= S14W'(s28_w[i] >>> FracBits);
    end

    err4_q <= err3_q;
    nrm4_q <= nrm3_q;
    for (int i = 0; i < 3; i++) begin
      pm4_q[i] <= 53'($signed({1'b0, ratio3_q})) * 53'(s14_q[i]);
    end

    err5_q <= err4_q;
    nrm5_q <= nrm4_q;
    for (int i = 0; i < 3; i++) begin
      perp5_q[i] <= PerpW'(p14_w[i]);
    end

    err6_q  <= err5_q;
    nrm6_q  <= nrm5_q;
    perp6_q <= perp5_q;
    for (int i = 0; i < 3; i++) begin
      sq6_q[i] <= LenW'(pe_w[i] * pe_w[i]);
    end

    err7_q  <= err6_q;
    nrm7_q  <= nrm6_q;
    perp7_q <= perp6_q;
    diff7_q <= (lensq_w >= OneQ28l) ? lensq_w - OneQ28l : OneQ28l - lensq_w;
  end

  assign item_o.valid = valid_q[VecStages-1];
  assign item_o.err   = err7_q;
  assign item_o.nrm   = nrm7_q;
  assign item_o.perp  = perp7_q;
  assign item_o.diff  = diff7_q;

endmodule

FILE: src/rrd_sqrt.sv
module rrd_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrd_pkg::len_item_t  item_i,
  output rrd_pkg::root_item_t item_o
);
  import rrd_pkg::*;

  // one root bit per stage, MSB first
  logic      valid_q [RootW];
  logic      err_q   [RootW];
  cvec_t     nrm_q   [RootW];
  pvec_t     perp_q  [RootW];
  sq_state_t st_q    [RootW];
  sq_state_t st0;

  function automatic logic [LenW:0] step_bit(input int s);
    return (LenW+1)'(1) << (2 * (RootW - 1 - s));
  endfunction

  function automatic sq_state_t sq_step(input sq_state_t st, input logic [LenW:0] bit_v);
    logic [LenW:0] t;
    sq_state_t     nx;
    t  = st.res + bit_v;
    nx = st;
    if ({1'b0, st.rad} >= t) begin
      nx.rad = st.rad - t[LenW-1:0];
      nx.res = (st.res >> 1) + bit_v;
    end else begin
      nx.res = st.res >> 1;
    end
    return nx;
  endfunction

  assign st0.rad = item_i.diff;
  assign st0.res = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < RootW; s++) valid_q[s] <= 1'b0;
    end else begin
      valid_q[0] <= item_i.valid;
      for (int s = 1; s < RootW; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]   <= sq_step(st0, step_bit(0));
    err_q[0]  <= item_i.err;
    nrm_q[0]  <= item_i.nrm;
    perp_q[0] <= item_i.perp;
    for (int s = 1; s < RootW; s++) begin
      st_q[s]   <= sq_step(st_q[s-1], step_bit(s));
      err_q[s]  <= err_q[s-1];
      nrm_q[s]  <= nrm_q[s-1];
      perp_q[s] <= perp_q[s-1];
    end
  end

  assign item_o.valid = valid_q[RootW-1];
  assign item_o.err   = err_q[RootW-1];
  assign item_o.nrm   = nrm_q[RootW-1];
  assign item_o.perp  = perp_q[RootW-1];
  assign item_o.root  = st_q[RootW-1].res[RootW-1:0];

endmodule

FILE: src/rrd_out.sv
module rrd_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rrd_pkg::root_item_t             item_i,
  output logic                            valid_o,
  output logic signed [rrd_pkg::OutW-1:0] out_x_o,
  output logic signed [rrd_pkg::OutW-1:0] out_y_o,
  output logic signed [rrd_pkg::OutW-1:0] out_z_o,
  output logic                            err_o
);
  import rrd_pkg::*;

  localparam logic signed [41:0] OutMax = (42'sd1 <<< (OutW-1)) - 42'sd1;
  localparam logic signed [41:0] OutMin = -(42'sd1 <<< (OutW-1));

  logic [OutStages-1:0]     valid_q;
  logic                     err1_q;
  pvec_t                    perp1_q;
  logic signed [40:0]       m1_q [3];
  logic                     err2_q;
  logic signed [OutW-1:0]   o2_q [3];

  logic signed [41:0]       par_w [3];
  logic signed [41:0]       sum_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      par_w[i] = (-42'(m1_q[i])) >>> FracBits;
      sum_w[i] = 42'($signed(perp1_q[i])) + par_w[i];
      if (sum_w[i] > OutMax) begin
        sum_w[i] = OutMax;
      end else if (sum_w[i] < OutMin) begin
        sum_w[i] = OutMin;
      end
      if (err1_q) begin
        sum_w[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[OutStages-2:0], item_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    err1_q  <= item_i.err;
    perp1_q <= item_i.perp;
    for (int i = 0; i < 3; i++) begin
      m1_q[i] <= 41'($signed(item_i.nrm[i])) * 41'($signed({1'b0, item_i.root}));
      o2_q[i] <= OutW'(sum_w[i]);
    end
    err2_q <= err1_q;
  end

  assign valid_o = valid_q[OutStages-1];
  assign err_o   = err2_q;
  assign out_x_o = o2_q[0];
  assign out_y_o = o2_q[1];
  assign out_z_o = o2_q[2];

endmodule

FILE: src/ray_refraction_direction.sv
// Refracted ray direction by Snell's law, fixed point.
// Input channel: start_i with ray_*_i, normal_*_i (Q2.14) and index_in_i,
//   index_out_i (unsigned Q3.13). An item is taken at each edge with start_i
//   high; busy_o is always low, so a new ray may enter every cycle.
// Output channel: done_o marks one cycle carrying out_*_o (Q6.14, saturated)
//   and index_error_o. Results leave in the order the rays came in.
// Pipeline: 30 stages of the index divider (one quotient bit each), 7 vector
//   stages (dot, cosine, sum, ratio product, clamp, squares, |1 - len^2|),
//   25 square-root stages (one root bit each) and 2 output stages.
// Throughput: one item per cycle, fixed by the fully pipelined divider and
//   square root.
// A zero outgoing index sets index_error_o and zeroes the vector.
// Reset clears the valid bits only; items in flight are dropped.
// The receiver cannot stall, so no back-pressure exists in the pipeline.
module ray_refraction_direction (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [rrd_pkg::CompW-1:0] ray_x_i,
  input  logic signed [rrd_pkg::CompW-1:0] ray_y_i,
  input  logic signed [rrd_pkg::CompW-1:0] ray_z_i,
  input  logic signed [rrd_pkg::CompW-1:0] normal_x_i,
  input  logic signed [rrd_pkg::CompW-1:0] normal_y_i,
  input  logic signed [rrd_pkg::CompW-1:0] normal_z_i,
  input  logic [rrd_pkg::IdxW-1:0]         index_in_i,
  input  logic [rrd_pkg::IdxW-1:0]         index_out_i,
  output logic                            done_o,
  output logic signed [rrd_pkg::OutW-1:0]  out_x_o,
  output logic signed [rrd_pkg::OutW-1:0]  out_y_o,
  output logic signed [rrd_pkg::OutW-1:0]  out_z_o,
  output logic                            index_error_o
);
  import rrd_pkg::*;
  `include "ray_refraction_direction_assert.svh"

  ratio_item_t ratio_item;
  len_item_t   len_item;
  root_item_t  root_item;
  cvec_t       ray_v, nrm_v;
  logic        accept;

  // pipeline never holds back
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign ray_v = {ray_z_i, ray_y_i, ray_x_i};
  assign nrm_v = {normal_z_i, normal_y_i, normal_x_i};

  // ratio = (index_in << 14) / index_out
  rrd_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .ray_i     (ray_v),
    .nrm_i     (nrm_v),
    .idx_in_i  (index_in_i),
    .idx_out_i (index_out_i),
    .item_o    (ratio_item)
  );

  // cosine, perpendicular part and |1 - |perp|^2|
  rrd_vec u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (ratio_item),
    .item_o (len_item)
  );

  rrd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (len_item),
    .item_o (root_item)
  );

  // parallel part, final sum and saturation
  rrd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (root_item),
    .valid_o (done_o),
    .out_x_o (out_x_o),
    .out_y_o (out_y_o),
    .out_z_o (out_z_o),
    .err_o   (index_error_o)
  );

  `RRD_ASSERT_DLY(a_lat_done, accept, Latency, done_o, "result missing after accept")
  `RRD_ASSERT_DLY(a_no_spurious, !accept, Latency, !done_o, "result without an item")
  `RRD_ASSERT_DLY(a_err_flag, accept && (index_out_i == '0), Latency, index_error_o, "zero index not flagged")
  `RRD_ASSERT_NOW(a_err_zero, done_o && index_error_o, (out_x_o == '0) && (out_y_o == '0) && (out_z_o == '0), "error result not zero")

endmodule

FILE: tb/sv/ray_refraction_direction_test.sv
module ray_refraction_direction_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrd_pkg::*;

  // One refracted direction as the block should report it.
  typedef struct {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] z;
    logic                   err;
  } refr_t;

  // Scoreboard: predicts each accepted ray, checks results in arrival order.
  class refr_board;
    refr_t pending[$];
    int    errors;

    static function longint fdiv(longint v, int s);
      return v >>> s;  // arithmetic shift floors toward minus infinity
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    static function longint int_sqrt(longint a);
      longint r, b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > a) b = b >> 2;
      while (b != 0) begin
        if (a >= r + b) begin
          a = a - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_ray(logic signed [CompW-1:0] ray[3],
                           logic signed [CompW-1:0] nrm[3],
                           logic [IdxW-1:0] n_in, logic [IdxW-1:0] n_out);
      refr_t  e;
      longint ratio, dotp, cosv, lensq, diff, root, s14, p, o[3], perp[3];
      e = '{x: '0, y: '0, z: '0, err: 1'b0};
      if (n_out == 0) begin
        e.err = 1'b1;
      end else begin
        ratio = (longint'(n_in) << FracBits) / longint'(n_out);
        dotp = 0;
        for (int i = 0; i < 3; i++) dotp += longint'(ray[i]) * longint'(nrm[i]);
        cosv = -dotp;
        if (cosv > (64'sd1 << 28)) cosv = 64'sd1 << 28;
        cosv = fdiv(cosv, FracBits);
        lensq = 0;
        for (int i = 0; i < 3; i++) begin
          s14 = fdiv((longint'(ray[i]) <<< FracBits) + cosv * longint'(nrm[i]), FracBits);
          p = fdiv(ratio * s14, FracBits);
          perp[i] = clip(p, -(64'sd1 << 24), (64'sd1 << 24) - 1);
          lensq += perp[i] * perp[i];
        end
        diff = (64'sd1 << 28) - lensq;
        if (diff < 0) diff = -diff;
        root = int_sqrt(diff);
        for (int i = 0; i < 3; i++)
          o[i] = clip(perp[i] + fdiv(-(longint'(nrm[i]) * root), FracBits),
                      -524288, 524287);
        e.x = o[0][OutW-1:0];
        e.y = o[1][OutW-1:0];
        e.z = o[2][OutW-1:0];
      end
      pending.push_back(e);
    endfunction

    function void check_result(refr_t got);
      refr_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no ray outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) report_mismatch($sformatf("out_x %0d exp %0d", got.x, e.x));
      if (got.y !== e.y) report_mismatch($sformatf("out_y %0d exp %0d", got.y, e.y));
      if (got.z !== e.z) report_mismatch($sformatf("out_z %0d exp %0d", got.z, e.z));
      if (got.err !== e.err)
        report_mismatch($sformatf("index_error %0b exp %0b", got.err, e.err));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, done_o, index_error_o;
  logic signed [CompW-1:0] ray_x_i, ray_y_i, ray_z_i;
  logic signed [CompW-1:0] normal_x_i, normal_y_i, normal_z_i;
  logic [IdxW-1:0] index_in_i, index_out_i;
  logic signed [OutW-1:0] out_x_o, out_y_o, out_z_o;

  refr_board board;
  longint    cycles;
  localparam longint CycleLimit = 200000;

  ray_refraction_direction u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    board = new();
    cycles = 0;
  end

  // Sample results and check at every edge; the receiver never stalls.
  always @(posedge clk_i) begin
    refr_t got;
    cycles <= cycles + 1;
    if (rst_ni && done_o === 1'b1) begin
      got.x = out_x_o;
      got.y = out_y_o;
      got.z = out_z_o;
      got.err = index_error_o;
      board.check_result(got);
    end
  end

  // Present one ray, hold it until the edge that takes it, then note it.
  task automatic send_ray(logic [15:0] rx, ry, rz, nx, ny, nz, ni, no, int gap);
    logic signed [CompW-1:0] r[3], n[3];
    repeat (gap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    ray_x_i <= rx; ray_y_i <= ry; ray_z_i <= rz;
    normal_x_i <= nx; normal_y_i <= ny; normal_z_i <= nz;
    index_in_i <= ni; index_out_i <= no;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    r = '{rx, ry, rz};
    n = '{nx, ny, nz};
    board.note_ray(r, n, ni, no);
  endtask

  // Mostly components within [-1, 1] and plausible indices; some raw bit noise.
  function automatic logic [15:0] comp_val(bit wild);
    if (wild) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  initial begin
    int gap;
    bit wild, burst;
    logic [15:0] ni, no;
    start_i = 1'b0;
    rst_ni = 1'b0;
    {ray_x_i, ray_y_i, ray_z_i, normal_x_i, normal_y_i, normal_z_i} = '0;
    index_in_i = '0;
    index_out_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: head-on, glancing, index extremes, zero indices, field extremes.
    send_ray(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h2000, 16'h2000, 0);
    send_ray(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h2000, 16'h2AA8, 0);
    send_ray(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h3000, 16'h2000, 0);
    send_ray(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'hFFFF, 16'h0001, 0);
    send_ray(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h0001, 16'hFFFF, 0);
    send_ray(16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 16'h4000, 16'h0000, 16'h2000, 16'h0000, 0);
    send_ray(16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h2000, 0);
    send_ray(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h2000, 16'h2000, 0);
    send_ray(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0001, 0);
    send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0001, 1);
    send_ray(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 2);
    send_ray(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 0);
    send_ray(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_ray(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 0);
    send_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);

    // Random: bursts of back-to-back rays alternate with random gaps.
    for (int k = 0; k < 1250; k++) begin
      if (k % 100 == 0) burst = $urandom_range(0, 1);
      gap = burst ? 0 : $urandom_range(0, 5);
      wild = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       no = 16'h0000;
        1:       no = 16'($urandom);
        default: no = 16'($urandom_range(8192, 24576));
      endcase
      ni = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24576));
      send_ray(comp_val(wild), comp_val(wild), comp_val(wild),
               comp_val(wild), comp_val(wild), comp_val(wild), ni, no, gap);
    end
    start_i <= 1'b0;

    while (board.pending.size() != 0 && cycles < CycleLimit) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog on total run length.
  initial begin
    wait (cycles >= CycleLimit);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
